// ----- rtl/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, codes and sizes for the pixel replicating upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_SCALE = 100;

  localparam int unsigned SCALE_W     = 7;
  localparam int unsigned ROW_WIDTH_W = 11;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE     = 8'd0,
    REG_ROW_WIDTH = 8'd1
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_PULL = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_PIXEL    = 3'd2,
    ST_PAD      = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic       source_done;
  } out_t;

  // classified item held between front and back
  typedef struct packed {
    action_e op;
    pixel_t  pixel;
  } item_t;

endpackage

// ----- rtl/pru_front.sv -----
// ----------------------------------------------------------------------------
// pru_front
// Accepts input beats, classifies them and holds them in a two entry queue.
// ----------------------------------------------------------------------------
module pru_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pru_pkg::in_t  in_data_i,
  output logic          item_valid_o,
  output pru_pkg::item_t item_o,
  input  logic          item_pop_i
);
  import pru_pkg::*;

  item_t      queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  item_t      item_in;

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && (count_q != 2'd0);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = queue_q[rd_ptr_q];

  // classify the action and pack the pixel
  always_comb begin
    item_in.op          = in_data_i.action ? ACT_PULL : ACT_LOAD;
    item_in.pixel.blue  = in_data_i.blue;
    item_in.pixel.green = in_data_i.green;
    item_in.pixel.red   = in_data_i.red;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = 2'(count_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- rtl/pru_back.sv -----
// ----------------------------------------------------------------------------
// pru_back
// Runs queued items against the line store and counters, drives results.
// ----------------------------------------------------------------------------
module pru_back #(
  parameter int unsigned MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [pru_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            item_valid_i,
  input  pru_pkg::item_t                  item_i,
  output logic                            item_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pru_pkg::out_t                   out_data_o
);
  import pru_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW = $clog2(MAX_SCALE + 1);

  // effective configuration
  logic [CW-1:0] eff_w_q;
  logic [SW-1:0] eff_s_q;
  logic [1:0]    pads;
  logic [SCALE_W-1:0]     scale_raw;
  logic [ROW_WIDTH_W-1:0] width_raw;

  // walk state
  logic [CW-1:0] load_cnt_q, load_cnt_d;
  logic          full_q, full_d;
  logic [CW-1:0] col_q, col_d;
  logic [SW-1:0] prep_q, prep_d;
  logic [SW-1:0] rrep_q, rrep_d;
  logic [1:0]    pad_q, pad_d;

  // execute step
  logic          exec_go;
  logic          wr_en, rd_en, row_end, done;
  status_e       st;
  logic [CW-1:0] cnt_inc, col_inc;
  logic [SW-1:0] prep_inc, rrep_inc;
  logic [1:0]    pad_inc;

  pixel_t        store [MAX_WIDTH];
  pixel_t        rdata_q;

  logic          p1_valid_q, p1_row_end_q, p1_done_q, p1_adv;
  status_e       p1_st_q;
  logic          out_valid_q;
  out_t          out_q;

  assign scale_raw = cfg_data_i[SCALE_W-1:0];
  assign width_raw = cfg_data_i[ROW_WIDTH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= CW'(1);
      eff_s_q <= SW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCALE: begin
          if (scale_raw == '0) eff_s_q <= SW'(1);
          else if (32'(scale_raw) > MAX_SCALE) eff_s_q <= SW'(MAX_SCALE);
          else eff_s_q <= SW'(scale_raw);
        end
        REG_ROW_WIDTH: begin
          if (width_raw == '0) eff_w_q <= CW'(1);
          else if (32'(width_raw) > MAX_WIDTH) eff_w_q <= CW'(MAX_WIDTH);
          else eff_w_q <= CW'(width_raw);
        end
        default: ;
      endcase
    end
  end

  // (w * s) mod 4 only depends on the low two bits of each
  assign pads = 2'(4'(2'(eff_w_q)) * 4'(2'(eff_s_q)));

  assign p1_adv     = p1_valid_q && (!out_valid_q || !out_stall_i);
  assign exec_go    = item_valid_i && (!p1_valid_q || p1_adv);
  assign item_pop_o = exec_go;

  always_comb begin
    load_cnt_d = load_cnt_q;
    full_d     = full_q;
    col_d      = col_q;
    prep_d     = prep_q;
    rrep_d     = rrep_q;
    pad_d      = pad_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    row_end    = 1'b0;
    done       = 1'b0;
    st         = ST_EMPTY;
    cnt_inc    = load_cnt_q + CW'(1);
    col_inc    = col_q + CW'(1);
    prep_inc   = prep_q + SW'(1);
    rrep_inc   = rrep_q + SW'(1);
    pad_inc    = pad_q + 2'd1;

    if (item_i.op == ACT_LOAD) begin
      if (full_q) begin
        st = ST_REJECTED;
      end else begin
        st         = ST_LOADED;
        wr_en      = (32'(load_cnt_q) < MAX_WIDTH);
        load_cnt_d = cnt_inc;
        if (cnt_inc >= eff_w_q) full_d = 1'b1;
      end
    end else if (!full_q) begin
      st = ST_EMPTY;
    end else if (col_q < eff_w_q) begin
      st    = ST_PIXEL;
      rd_en = 1'b1;
      if (prep_inc >= eff_s_q) begin
        prep_d = '0;
        col_d  = col_inc;
        if (col_inc >= eff_w_q && pads == 2'd0) row_end = 1'b1;
      end else begin
        prep_d = prep_inc;
      end
    end else begin
      st    = ST_PAD;
      pad_d = pad_inc;
      if (pad_inc >= pads || pad_inc == 2'd0) row_end = 1'b1;
    end

    if (row_end) begin
      col_d  = '0;
      prep_d = '0;
      pad_d  = '0;
      if (rrep_inc >= eff_s_q) begin
        done       = 1'b1;
        rrep_d     = '0;
        full_d     = 1'b0;
        load_cnt_d = '0;
      end else begin
        rrep_d = rrep_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      full_q     <= 1'b0;
      col_q      <= '0;
      prep_q     <= '0;
      rrep_q     <= '0;
      pad_q      <= '0;
    end else if (exec_go) begin
      load_cnt_q <= load_cnt_d;
      full_q     <= full_d;
      col_q      <= col_d;
      prep_q     <= prep_d;
      rrep_q     <= rrep_d;
      pad_q      <= pad_d;
    end
  end

  // line store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (exec_go && wr_en) begin
      store[load_cnt_q[AW-1:0]] <= item_i.pixel;
    end
    if (exec_go && rd_en) begin
      rdata_q <= store[col_q[AW-1:0]];
    end
  end

  // stage waiting on read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (exec_go) begin
      p1_valid_q <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      p1_st_q      <= st;
      p1_row_end_q <= row_end;
      p1_done_q    <= done;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      out_q.status      <= p1_st_q;
      out_q.out_blue    <= (p1_st_q == ST_PIXEL) ? rdata_q.blue : 8'h00;
      out_q.out_green   <= (p1_st_q == ST_PIXEL) ? rdata_q.green : 8'h00;
      out_q.out_red     <= (p1_st_q == ST_PIXEL) ? rdata_q.red : 8'h00;
      out_q.row_end     <= p1_row_end_q;
      out_q.source_done <= p1_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/pixel_replicating_upscaler.sv -----
// ----------------------------------------------------------------------------
// pixel_replicating_upscaler
// Nearest neighbor integer upscaler for 24-bit BGR scanlines.
// ----------------------------------------------------------------------------
// A load beat writes one source pixel into the line store; once a full row
// is held, each pull beat returns the next output unit: every pixel repeated
// scale times, then (width*scale) mod 4 zero pad bytes, the whole row
// repeated scale times before the store is freed. Every input beat gives
// exactly one result beat, in order. The block sustains one beat per clock
// in each direction while the output is not stalled; an accepted beat passes
// through the queue entry, the execute step with its line store read and the
// output register before its result shows. The rate is set by the single step
// that updates the row counters each cycle and by the registered read port of
// the line store. Configuration writes are taken in any cycle (ready is
// always high) and must only be issued while no results are pending.
module pixel_replicating_upscaler #(
  parameter int unsigned MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pru_pkg::in_t                   in_data_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pru_pkg::out_t                  out_data_o
);
  import pru_pkg::*;

  logic  item_valid;
  item_t item;
  logic  item_pop;

  // registers are plain flops, never busy
  assign cfg_ready_o = 1'b1;

  // front: accept and classify into a short queue
  pru_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back: counters, line store and result register
  pru_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
